// ----- src/board_irq_priority_controller_defines.svh -----
// Assertion helpers used by the top module of the interrupt combiner.
`ifndef BOARD_IRQ_PRIORITY_CONTROLLER_DEFINES_SVH
`define BOARD_IRQ_PRIORITY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BIPC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("interrupt combiner check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BIPC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("interrupt combiner check failed");

`endif

// ----- src/bipc_pkg.sv -----
package bipc_pkg;

  localparam int NUM_SOURCES_DEF = 13;
  localparam int MAX_SOURCES     = 16;

  // Request kinds
  localparam logic [1:0] REQ_SOURCE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  // Register window offsets
  localparam logic [5:0] OFS_MASK    = 6'h00;
  localparam logic [5:0] OFS_POWOFF  = 6'h30;
  localparam logic [5:0] OFS_VERSION = 6'h32;
  localparam logic [5:0] OFS_OUTPORT = 6'h36;

  localparam logic [15:0] VERSION_VAL = 16'h0010;
  localparam logic [3:0]  NO_LEVEL    = 4'd15;

  // Monitor bit of each source; unused slots have no bit
  localparam logic [15:0] SRC_BIT [MAX_SOURCES] = '{
    16'h0800, 16'h0200, 16'h0100, 16'h1000, 16'h0400, 16'h0040, 16'h0020, 16'h0010,
    16'h0080, 16'h4000, 16'h2000, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000
  };

  // Fixed priority level of each source; lower wins
  localparam logic [3:0] SRC_PRIO [MAX_SOURCES] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd15, 4'd15, 4'd15
  };

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  source_index;
    logic        source_level;
    logic [5:0]  bus_address;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irl_level_out;
    logic        shutdown_pulse;
  } rsp_t;

endpackage

// ----- src/bipc_irl_enc.sv -----
module bipc_irl_enc #(
  parameter int NumSources = bipc_pkg::NUM_SOURCES_DEF
) (
  input  logic [15:0] live,
  output logic [3:0]  irl
);

  logic [3:0] best;

  // Pick the lowest level among live sources; strict compare so lower wins
  always_comb begin
    best = bipc_pkg::NO_LEVEL;
    for (int i = NumSources - 1; i >= 0; i--) begin
      if ((live & bipc_pkg::SRC_BIT[i]) != 16'h0000 && bipc_pkg::SRC_PRIO[i] < best) begin
        best = bipc_pkg::SRC_PRIO[i];
      end
    end
    irl = best ^ bipc_pkg::NO_LEVEL;
  end

endmodule

// ----- src/board_irq_priority_controller.sv -----
// Board interrupt combiner: takes one item per clock while item_stall is low (source
// level change, bus read or bus write) and offers one result per item. The
// accepting edge loads the item into the input register, and the next
// free edge moves its result into the result register.
// The pending, mask and output-port registers update on the same edge that
// moves the result into the result register; the result carries the interrupt
// level as it stands after the item.
`include "board_irq_priority_controller_defines.svh"

module board_irq_priority_controller #(
  parameter int NUM_SOURCES = bipc_pkg::NUM_SOURCES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  bipc_pkg::req_t item,
  output logic           result_valid,
  input  logic           result_stall,
  output bipc_pkg::rsp_t result
);

  localparam logic [4:0] SRC_LIMIT = 5'(NUM_SOURCES);

  logic           s1_valid;
  bipc_pkg::req_t s1;
  logic [15:0]    pending_monitor;
  logic [15:0]    irq_mask;
  logic [15:0]    output_port;
  logic [15:0]    pending_monitor_next;
  logic [15:0]    irq_mask_next;
  logic [15:0]    output_port_next;
  bipc_pkg::rsp_t result_next;
  logic [3:0]     irl;
  logic           out_free;
  logic           s1_adv;
  logic           accept;

  // Handshake: result register frees when empty or taken
  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  // Decode the held item into state updates and a result
  always_comb begin
    pending_monitor_next     = pending_monitor;
    irq_mask_next            = irq_mask;
    output_port_next         = output_port;
    result_next.read_data    = 16'h0000;
    result_next.shutdown_pulse = 1'b0;
    case (s1.req_type)
      bipc_pkg::REQ_SOURCE: begin
        if ({1'b0, s1.source_index} < SRC_LIMIT) begin
          if (s1.source_level) begin
            pending_monitor_next = pending_monitor | bipc_pkg::SRC_BIT[s1.source_index];
          end else begin
            pending_monitor_next = pending_monitor & ~bipc_pkg::SRC_BIT[s1.source_index];
          end
        end
      end
      bipc_pkg::REQ_READ: begin
        case (s1.bus_address)
          bipc_pkg::OFS_MASK:    result_next.read_data = irq_mask;
          bipc_pkg::OFS_OUTPORT: result_next.read_data = output_port;
          bipc_pkg::OFS_VERSION: result_next.read_data = bipc_pkg::VERSION_VAL;
          default:               result_next.read_data = 16'h0000;
        endcase
      end
      bipc_pkg::REQ_WRITE: begin
        case (s1.bus_address)
          bipc_pkg::OFS_MASK:    irq_mask_next = s1.write_data;
          bipc_pkg::OFS_OUTPORT: output_port_next = s1.write_data;
          bipc_pkg::OFS_POWOFF:  result_next.shutdown_pulse = s1.write_data[0];
          default:               result_next.shutdown_pulse = 1'b0;
        endcase
      end
      default: begin
        result_next.read_data = 16'h0000;
      end
    endcase
    result_next.irl_level_out = irl;
  end

  // Encode the level seen after this item's update
  bipc_irl_enc #(
    .NumSources(NUM_SOURCES)
  ) u_irl_enc (
    .live(pending_monitor_next & irq_mask_next),
    .irl (irl)
  );

  // Hold control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      result_valid    <= 1'b0;
      pending_monitor <= 16'h0000;
      irq_mask        <= 16'h0000;
      output_port     <= 16'h0000;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid    <= 1'b1;
        pending_monitor <= pending_monitor_next;
        irq_mask        <= irq_mask_next;
        output_port     <= output_port_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
    if (s1_adv) begin
      result <= result_next;
    end
  end

  `BIPC_ASSERT_NOW(a_stall_only_full, item_stall, s1_valid && result_valid)
  `BIPC_ASSERT_NEXT(a_masked_quiet, s1_adv && (pending_monitor_next & irq_mask_next) == 16'h0000, result.irl_level_out == 4'd0)
  `BIPC_ASSERT_NEXT(a_shutdown_write, s1_adv && s1.req_type != bipc_pkg::REQ_WRITE, !result.shutdown_pulse)
  `BIPC_ASSERT_NEXT(a_read_zero, s1_adv && s1.req_type != bipc_pkg::REQ_READ, result.read_data == 16'h0000)

endmodule

// ----- verif/tb_board_irq_priority_controller.sv -----
module tb_board_irq_priority_controller;
  import bipc_pkg::*;

  localparam int NUM_SRC         = NUM_SOURCES_DEF;
  localparam logic [1:0] REQ_NONE = 2'd3;  // kind the block must pass through untouched
  localparam logic [5:0] OFS_DEAD = 6'h3f; // an offset nothing decodes
  localparam int HOLD_CYCLES     = 120;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  req_t item;
  logic result_valid;
  logic result_stall;
  rsp_t result;

  int send_idle_pct;
  int stall_pct;
  bit want_hold;
  int hold_left;
  int quiet_cycles;

  // Track the combiner state and hold the results it must produce, oldest first
  class irq_scoreboard;
    logic [15:0] pend_word;
    logic [15:0] mask_reg;
    logic [15:0] port_reg;
    rsp_t awaited_rsp[$];
    int errors;
    int n_items;
    int n_results;
    int n_sources;
    int n_reads;
    int n_writes;
    int n_pulses;

    function new();
      pend_word = '0;
      mask_reg  = '0;
      port_reg  = '0;
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      n_sources = 0;
      n_reads   = 0;
      n_writes  = 0;
      n_pulses  = 0;
    endfunction

    // Lowest priority level among unmasked pending sources, inverted
    function logic [3:0] irl_code();
      logic [15:0] live;
      logic [3:0] best;
      live = pend_word & mask_reg;
      best = NO_LEVEL;
      for (int i = 0; i < NUM_SRC && i < MAX_SOURCES; i++) begin
        if ((live & SRC_BIT[i]) != '0 && SRC_PRIO[i] < best) best = SRC_PRIO[i];
      end
      return best ^ NO_LEVEL;
    endfunction

    // Apply one item to the state and return the result it causes
    function rsp_t combine_item(req_t r);
      rsp_t o;
      o = '0;
      case (r.req_type)
        REQ_SOURCE: begin
          if (r.source_index < NUM_SRC) begin
            if (r.source_level) pend_word = pend_word | SRC_BIT[r.source_index];
            else pend_word = pend_word & ~SRC_BIT[r.source_index];
          end
        end
        REQ_READ: begin
          case (r.bus_address)
            OFS_MASK:    o.read_data = mask_reg;
            OFS_OUTPORT: o.read_data = port_reg;
            OFS_VERSION: o.read_data = VERSION_VAL;
            default:     o.read_data = '0;
          endcase
        end
        REQ_WRITE: begin
          case (r.bus_address)
            OFS_MASK:    mask_reg = r.write_data;
            OFS_OUTPORT: port_reg = r.write_data;
            OFS_POWOFF:  o.shutdown_pulse = r.write_data[0];
            default: ;
          endcase
        end
        default: ;
      endcase
      o.irl_level_out = irl_code();
      return o;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void note_item(req_t r);
      n_items++;
      if (r.req_type == REQ_SOURCE) n_sources++;
      if (r.req_type == REQ_READ) n_reads++;
      if (r.req_type == REQ_WRITE) n_writes++;
      awaited_rsp.push_back(combine_item(r));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      n_results++;
      if (got.shutdown_pulse) n_pulses++;
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("result %0d read_data 0x%0h, want 0x%0h",
                                  n_results, got.read_data, want.read_data));
      if (got.irl_level_out !== want.irl_level_out)
        report_mismatch($sformatf("result %0d irl_level_out %0d, want %0d",
                                  n_results, got.irl_level_out, want.irl_level_out));
      if (got.shutdown_pulse !== want.shutdown_pulse)
        report_mismatch($sformatf("result %0d shutdown_pulse %b, want %b",
                                  n_results, got.shutdown_pulse, want.shutdown_pulse));
    endtask

    task close_out();
      if (awaited_rsp.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", awaited_rsp.size()));
    endtask
  endclass

  irq_scoreboard sb;

  board_irq_priority_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Record accepted items and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // Stall the result side; a requested hold-off runs its full count first
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (want_hold) begin
      want_hold = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no item moved for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [3:0] idx, logic lvl,
                                    logic [5:0] addr, logic [15:0] data);
    req_t r;
    r.req_type     = kind;
    r.source_index = idx;
    r.source_level = lvl;
    r.bus_address  = addr;
    r.write_data   = data;
    return r;
  endfunction

  // Mostly well-formed traffic on decoded offsets; unused fields carry noise
  function automatic req_t random_req();
    req_t r;
    int pick;
    r = make_req(2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                 6'($urandom_range(63)), 16'($urandom_range(65535)));
    pick = $urandom_range(99);
    if (pick < 42) begin
      r.req_type = REQ_SOURCE;
      if ($urandom_range(9) != 0) r.source_index = 4'($urandom_range(NUM_SRC - 1));
    end else if (pick < 67) begin
      r.req_type = REQ_READ;
    end else if (pick < 95) begin
      r.req_type = REQ_WRITE;
    end else begin
      r.req_type = REQ_NONE;
    end
    if ($urandom_range(4) != 0) begin
      case ($urandom_range(3))
        0: r.bus_address = OFS_MASK;
        1: r.bus_address = OFS_POWOFF;
        2: r.bus_address = OFS_VERSION;
        default: r.bus_address = OFS_OUTPORT;
      endcase
    end
    return r;
  endfunction

  // Offer one item, idling first at the current rate, and wait until it is taken
  task automatic send_item(req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_VERSION, 16'h0000));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_MASK, 16'h0000));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_OUTPORT, 16'h0000));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_POWOFF, 16'h0000));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_DEAD, 16'hffff));
    // lowest-priority source while everything is masked
    send_item(make_req(REQ_SOURCE, 4'd12, 1'b1, 6'h00, 16'h0000));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_MASK, 16'hffff));
    // highest priority takes over, then releases
    send_item(make_req(REQ_SOURCE, 4'd0, 1'b1, 6'h00, 16'h0000));
    send_item(make_req(REQ_SOURCE, 4'd13, 1'b1, 6'h00, 16'h0000));
    send_item(make_req(REQ_SOURCE, 4'd15, 1'b0, 6'h3f, 16'hffff));
    send_item(make_req(REQ_SOURCE, 4'd0, 1'b0, 6'h00, 16'h0000));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_OUTPORT, 16'hffff));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_OUTPORT, 16'h0000));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_OUTPORT, 16'h0000));
    // power-off pulse only on bit 0
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_POWOFF, 16'h0001));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_POWOFF, 16'hfffe));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_VERSION, 16'hffff));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_VERSION, 16'h0000));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_DEAD, 16'hffff));
    send_item(make_req(REQ_NONE, 4'hf, 1'b1, 6'h3f, 16'hffff));
    send_item(make_req(REQ_READ, 4'd0, 1'b0, OFS_MASK, 16'h0000));
    send_item(make_req(REQ_WRITE, 4'd0, 1'b0, OFS_MASK, 16'h0000));
    send_item(make_req(REQ_SOURCE, 4'd12, 1'b0, 6'h00, 16'h0000));
  endtask

  task automatic run_phase(int idle, int stall, bit hold);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) want_hold = 1'b1;
    repeat (ITEMS_PER_PHASE) send_item(random_req());
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    result_stall  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    want_hold     = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    // back-to-back traffic with one long receiver hold-off to fill the block
    run_phase(0, 0, 1'b1);
    run_phase(68, 0, 1'b0);
    run_phase(0, 68, 1'b0);
    run_phase(19, 19, 1'b0);

    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("covered %0d items (%0d source changes, %0d reads, %0d writes) and %0d results",
             sb.n_items, sb.n_sources, sb.n_reads, sb.n_writes, sb.n_results);
    $display("saw %0d shutdown pulses across idle, stall and hold-off phases; %0d mismatches",
             sb.n_pulses, sb.errors);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bipc_pkg.sv
src/bipc_irl_enc.sv
src/board_irq_priority_controller.sv
verif/tb_board_irq_priority_controller.sv
